@@ design/closest_point_on_segment_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Closest point on segment - assertion macros
// Shared property wrappers for the concurrent checks of the unit.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_SEGMENT_UNIT_MACROS_SVH
`define CLOSEST_POINT_ON_SEGMENT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("closest point on segment: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("closest point on segment: assertion failed");

`endif

@@ design/cps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Closest point on segment - package
// Widths, payload structs, codes and the divider cell transaction type.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int CW   = 32;           // coordinate width
    localparam int QW   = CW + 2;       // quotient bits, one divider cell each
    localparam int DW   = 2 * CW + 3;   // divisor and remainder width
    localparam int NW   = DW + QW;      // dividend width
    localparam int PW   = 2 * CW + 2;   // signed 33x33 product width
    localparam int SW   = PW + 1;       // sum of two products
    localparam int DOTW = 2 * CW + 1;   // interior dot magnitude width
    localparam int FRONT_STAGES = 5;
    localparam int LAT  = FRONT_STAGES + QW + 1;

    typedef logic signed [CW-1:0] t_coord;

    typedef enum logic [1:0] {
        REG_INTERIOR = 2'd0,
        REG_START    = 2'd1,
        REG_END      = 2'd2
    } t_region;

    typedef enum logic [1:0] {
        CFG_START_X = 2'd0,
        CFG_START_Y = 2'd1,
        CFG_END_X   = 2'd2,
        CFG_END_Y   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_coord query_x;
        t_coord query_y;
    } t_in;

    typedef struct packed {
        t_coord  near_x;
        t_coord  near_y;
        t_region region;
    } t_out;

    typedef struct packed {
        logic          valid;
        t_region       region;
        logic          neg_x;
        logic          neg_y;
        logic [DW-1:0] den;
        logic [DW-1:0] rem_x;
        logic [DW-1:0] rem_y;
        logic [QW-1:0] acc_x;
        logic [QW-1:0] acc_y;
    } t_div;

endpackage
`default_nettype wire

@@ design/closest_point_on_segment_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Closest point on segment - top level
// Nearest point of a configured 2D segment to each query point, Q16.16.
// ----------------------------------------------------------------------------
// A query is taken at every clock edge with start high; busy stays low, so a
// new transaction may follow in every cycle. Each result appears on o_result
// for exactly one cycle with o_done high, in query order; the receiver cannot
// stall and must take it then. The pipeline is five setup stages (differences,
// products, classification, partial products, dividend), one divider cell per
// quotient bit (34 cells) and one output register. Write the segment registers
// only while no transaction is in flight.
`include "closest_point_on_segment_unit_macros.svh"

module closest_point_on_segment_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          start,
    output logic         busy,
    input  cps_pkg::t_in i_query,
    input  wire          i_cfg_we,
    input  wire [1:0]    i_cfg_idx,
    input  wire [31:0]   i_cfg_data,
    output logic         o_done,
    output cps_pkg::t_out o_result
);
    import cps_pkg::*;

    t_coord r_start_x, r_start_y, r_end_x, r_end_y;
    logic   w_accept;
    t_div   w_chain [0:QW];
    t_div   w_last;
    logic signed [CW+1:0] w_qx, w_qy;
    t_out   n_result;
    t_out   r_result;
    logic   r_done;

    // fully pipelined: never hold off a query
    assign busy     = 1'b0;
    assign w_accept = start && !busy && i_rst_n;

    // segment registers, reset to the origin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START_X: r_start_x <= t_coord'(i_cfg_data);
                CFG_START_Y: r_start_y <= t_coord'(i_cfg_data);
                CFG_END_X:   r_end_x   <= t_coord'(i_cfg_data);
                CFG_END_Y:   r_end_y   <= t_coord'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // setup stages: products, region decision, dividend and divisor
    cps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_query   (i_query),
        .i_start_x (r_start_x),
        .i_start_y (r_start_y),
        .i_end_x   (r_end_x),
        .i_end_y   (r_end_y),
        .o_div     (w_chain[0])
    );

    // divider chain: each cell resolves one quotient bit per axis
    for (genvar g = 0; g < QW; g++) begin : g_cell
        cps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_div   (w_chain[g]),
            .o_div   (w_chain[g+1])
        );
    end

    assign w_last = w_chain[QW];

    // apply the rounded offset with the sign of the segment direction
    always_comb begin
        w_qx = w_last.neg_x ? -(CW+2)'(w_last.acc_x) : (CW+2)'(w_last.acc_x);
        w_qy = w_last.neg_y ? -(CW+2)'(w_last.acc_y) : (CW+2)'(w_last.acc_y);
        n_result.region = w_last.region;
        case (w_last.region)
            REG_INTERIOR: begin
                n_result.near_x = t_coord'((CW+2)'(r_start_x) + w_qx);
                n_result.near_y = t_coord'((CW+2)'(r_start_y) + w_qy);
            end
            REG_END: begin
                n_result.near_x = r_end_x;
                n_result.near_y = r_end_y;
            end
            default: begin
                n_result.near_x = r_start_x;
                n_result.near_y = r_start_y;
            end
        endcase
    end

    // output register: drive the result for one cycle
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_done   <= w_last.valid;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // every result traces back to a query accepted the fixed latency earlier
    `CPS_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_done,
        $past(w_accept, LAT))
    // every accepted query yields its result after the fixed latency
    `CPS_ASSERT_NXT(a_result_due, i_clk, i_rst_n, w_accept,
        ##(LAT-1) o_done)
    // start-endpoint results carry the start registers
    `CPS_ASSERT_IMP(a_start_pt, i_clk, i_rst_n, o_done && o_result.region == REG_START,
        o_result.near_x == $past(r_start_x) && o_result.near_y == $past(r_start_y))
    // end-endpoint results carry the end registers
    `CPS_ASSERT_IMP(a_end_pt, i_clk, i_rst_n, o_done && o_result.region == REG_END,
        o_result.near_x == $past(r_end_x) && o_result.near_y == $past(r_end_y))

endmodule
`default_nettype wire

@@ design/cps_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Closest point on segment - divider cell
// One restoring division step for both axes; hands its result to the next cell.
// ----------------------------------------------------------------------------
module cps_cell (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  cps_pkg::t_div i_div,
    output cps_pkg::t_div o_div
);
    import cps_pkg::*;

    t_div        r_div;
    t_div        n_div;
    logic [DW:0] w_sh_x;
    logic [DW:0] w_sh_y;
    logic        w_ge_x;
    logic        w_ge_y;
    logic [DW:0] w_sub_x;
    logic [DW:0] w_sub_y;

    always_comb begin
        w_sh_x  = {i_div.rem_x, i_div.acc_x[QW-1]};
        w_sh_y  = {i_div.rem_y, i_div.acc_y[QW-1]};
        w_ge_x  = w_sh_x >= {1'b0, i_div.den};
        w_ge_y  = w_sh_y >= {1'b0, i_div.den};
        w_sub_x = w_sh_x - {1'b0, i_div.den};
        w_sub_y = w_sh_y - {1'b0, i_div.den};
        n_div       = i_div;
        // remainder stays below the divisor, so the top bit drops
        n_div.rem_x = w_ge_x ? w_sub_x[DW-1:0] : w_sh_x[DW-1:0];
        n_div.rem_y = w_ge_y ? w_sub_y[DW-1:0] : w_sh_y[DW-1:0];
        n_div.acc_x = {i_div.acc_x[QW-2:0], w_ge_x};
        n_div.acc_y = {i_div.acc_y[QW-2:0], w_ge_y};
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
        if (!i_rst_n) begin
            r_div.valid <= 1'b0;
        end
    end

    assign o_div = r_div;

endmodule
`default_nettype wire

@@ design/cps_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Closest point on segment - front pipeline
// Differences, products, classification and dividend setup in five stages.
// ----------------------------------------------------------------------------
module cps_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  cps_pkg::t_in    i_query,
    input  cps_pkg::t_coord i_start_x,
    input  cps_pkg::t_coord i_start_y,
    input  cps_pkg::t_coord i_end_x,
    input  cps_pkg::t_coord i_end_y,
    output cps_pkg::t_div   o_div
);
    import cps_pkg::*;

    // stage 1: differences
    logic                 r_v1;
    logic signed [CW:0]   r_px, r_py, r_ex, r_ey, r_dx1, r_dy1;
    // stage 2: products
    logic                 r_v2;
    logic signed [PW-1:0] r_pdx, r_pdy, r_dxx, r_dyy, r_ppx, r_ppy, r_eex, r_eey;
    logic signed [CW:0]   r_dx2, r_dy2;
    // stage 3: classification
    logic                 r_v3;
    t_region              r_reg3;
    logic [DOTW-1:0]      r_dot;
    logic [SW-1:0]        r_len3;
    logic [CW:0]          r_adx3, r_ady3;
    logic                 r_nx3, r_ny3;
    // stage 4: partial products
    logic                 r_v4;
    t_region              r_reg4;
    logic [2*CW+1:0]      r_lox, r_loy;
    logic [2*CW:0]        r_hix, r_hiy;
    logic [SW-1:0]        r_len4;
    logic                 r_nx4, r_ny4;
    // stage 5
    t_div                 r_div;

    logic signed [SW-1:0] w_dot, w_len2, w_d0, w_d1;
    t_region              w_reg;
    logic [NW-1:0]        w_prod_x, w_prod_y, w_num_x, w_num_y;

    always_comb begin
        w_dot  = SW'(r_pdx) + SW'(r_pdy);
        w_len2 = SW'(r_dxx) + SW'(r_dyy);
        w_d0   = SW'(r_ppx) + SW'(r_ppy);
        w_d1   = SW'(r_eex) + SW'(r_eey);
        if (w_len2 == '0) begin
            w_reg = REG_START;
        end else if (w_dot > 0 && w_dot < w_len2) begin
            w_reg = REG_INTERIOR;
        end else if (w_d0 < w_d1) begin
            w_reg = REG_START;
        end else begin
            w_reg = REG_END;
        end
        w_prod_x = NW'(r_lox) + (NW'(r_hix) << (CW + 1));
        w_prod_y = NW'(r_loy) + (NW'(r_hiy) << (CW + 1));
        // round half away: (2|n| + d) / (2d)
        w_num_x  = (w_prod_x << 1) + NW'(r_len4);
        w_num_y  = (w_prod_y << 1) + NW'(r_len4);
    end

    always_ff @(posedge i_clk) begin
        r_px  <= (CW+1)'(i_query.query_x) - (CW+1)'(i_start_x);
        r_py  <= (CW+1)'(i_query.query_y) - (CW+1)'(i_start_y);
        r_ex  <= (CW+1)'(i_query.query_x) - (CW+1)'(i_end_x);
        r_ey  <= (CW+1)'(i_query.query_y) - (CW+1)'(i_end_y);
        r_dx1 <= (CW+1)'(i_end_x) - (CW+1)'(i_start_x);
        r_dy1 <= (CW+1)'(i_end_y) - (CW+1)'(i_start_y);

        r_pdx <= r_px * r_dx1;
        r_pdy <= r_py * r_dy1;
        r_dxx <= r_dx1 * r_dx1;
        r_dyy <= r_dy1 * r_dy1;
        r_ppx <= r_px * r_px;
        r_ppy <= r_py * r_py;
        r_eex <= r_ex * r_ex;
        r_eey <= r_ey * r_ey;
        r_dx2 <= r_dx1;
        r_dy2 <= r_dy1;

        r_reg3 <= w_reg;
        r_dot  <= w_dot[DOTW-1:0];
        r_len3 <= w_len2;
        r_nx3  <= r_dx2[CW];
        r_ny3  <= r_dy2[CW];
        r_adx3 <= r_dx2[CW] ? -r_dx2 : r_dx2;
        r_ady3 <= r_dy2[CW] ? -r_dy2 : r_dy2;

        r_reg4 <= r_reg3;
        r_lox  <= r_dot[CW:0] * r_adx3;
        r_loy  <= r_dot[CW:0] * r_ady3;
        r_hix  <= r_dot[DOTW-1:CW+1] * r_adx3;
        r_hiy  <= r_dot[DOTW-1:CW+1] * r_ady3;
        r_len4 <= r_len3;
        r_nx4  <= r_nx3;
        r_ny4  <= r_ny3;

        r_div.region <= r_reg4;
        r_div.neg_x  <= r_nx4;
        r_div.neg_y  <= r_ny4;
        r_div.den    <= DW'(r_len4) << 1;
        r_div.rem_x  <= w_num_x[NW-1:QW];
        r_div.rem_y  <= w_num_y[NW-1:QW];
        r_div.acc_x  <= w_num_x[QW-1:0];
        r_div.acc_y  <= w_num_y[QW-1:0];

        r_v1        <= i_valid;
        r_v2        <= r_v1;
        r_v3        <= r_v2;
        r_v4        <= r_v3;
        r_div.valid <= r_v4;
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_div.valid <= 1'b0;
        end
    end

    assign o_div = r_div;

endmodule
`default_nettype wire

@@ tb/sv/tb_closest_point_on_segment_unit.sv @@
// ----------------------------------------------------------------------------
// Closest point on segment - testbench
// Streams query points against a series of segments and checks each nearest
// point and region code against a wide-integer prediction of the unit.
// ----------------------------------------------------------------------------
module tb_closest_point_on_segment_unit;
    import cps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    t_in           i_query;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [31:0]   i_cfg_data;
    logic          o_done;
    t_out          o_result;

    // segment as the unit holds it
    t_coord seg_ax, seg_ay, seg_bx, seg_by;

    t_out   nearest_q[$];
    int     mismatches;
    int     queries_sent;
    int     results_seen;
    int     idle_cycles;
    int     segments_used;
    bit     sender_may_idle;

    closest_point_on_segment_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_query    (i_query),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Divide with rounding to nearest, ties away from zero; den > 0.
    function automatic logic signed [199:0] div_round(logic signed [199:0] num,
                                                      logic signed [199:0] den);
        logic signed [199:0] mag;
        logic signed [199:0] q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    // Nearest point of the current segment to one query point.
    function automatic t_out nearest_point(t_in q);
        logic signed [199:0] ax, ay, bx, by, qx, qy, dx, dy, px, py, ex, ey;
        logic signed [199:0] len2, dot, d0, d1;
        t_out r;
        ax = seg_ax; ay = seg_ay; bx = seg_bx; by = seg_by;
        qx = q.query_x; qy = q.query_y;
        dx = bx - ax; dy = by - ay;
        if (dx == 0 && dy == 0) begin
            r.near_x = seg_ax; r.near_y = seg_ay; r.region = REG_START;
            return r;
        end
        px = qx - ax; py = qy - ay;
        len2 = dx * dx + dy * dy;
        dot = px * dx + py * dy;
        if (dot > 0 && dot < len2) begin
            r.near_x = t_coord'(ax + div_round(dot * dx, len2));
            r.near_y = t_coord'(ay + div_round(dot * dy, len2));
            r.region = REG_INTERIOR;
        end else begin
            ex = qx - bx; ey = qy - by;
            d0 = px * px + py * py;
            d1 = ex * ex + ey * ey;
            // equal distances go to the end point
            if (d0 < d1) begin
                r.near_x = seg_ax; r.near_y = seg_ay; r.region = REG_START;
            end else begin
                r.near_x = seg_bx; r.near_y = seg_by; r.region = REG_END;
            end
        end
        return r;
    endfunction

    // Send one query transaction, after a random idle gap when allowed.
    // Start stays high across back-to-back queries; drop it only for a gap.
    task automatic send_query(t_coord qx, t_coord qy);
        int gap;
        gap = sender_may_idle ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_query.query_x <= qx;
        i_query.query_y <= qy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        nearest_q.push_back(nearest_point('{query_x: qx, query_y: qy}));
        queries_sent++;
    endtask

    // Hold until every expected result has come, then let the pipe drain.
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge i_clk);
        while (nearest_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_coord value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_START_X: seg_ax = value;
            CFG_START_Y: seg_ay = value;
            CFG_END_X:   seg_bx = value;
            default:     seg_by = value;
        endcase
    endtask

    // Drain, then load a whole segment.
    task automatic load_segment(t_coord ax, t_coord ay, t_coord bx, t_coord by);
        drain_pipe();
        write_reg(CFG_START_X, ax);
        write_reg(CFG_START_Y, ay);
        write_reg(CFG_END_X, bx);
        write_reg(CFG_END_Y, by);
        i_cfg_we <= 1'b0;
        segments_used++;
    endtask

    function automatic t_coord rand_coord(int span);
        case ($urandom_range(0, 3))
            0:       return t_coord'($urandom);
            1:       return t_coord'($urandom_range(0, 2 * span) - span);
            2:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return t_coord'($signed($urandom_range(0, 2 * span) - span) <<< 16);
        endcase
    endfunction

    // Reset state of the segment is degenerate at the origin.
    task automatic test_reset_segment();
        send_query(32'sh7fff_ffff, 32'sh8000_0000);
        send_query(32'sh0001_0000, 32'sh0);
    endtask

    // Interior, both endpoints, an equidistant interior query and rounding ties.
    task automatic test_directed_cases();
        load_segment(32'sh0, 32'sh0, 32'sh0004_0000, 32'sh0);
        send_query(32'sh0001_8000, 32'sh0005_0000);   // interior
        send_query(-32'sh0001_0000, 32'sh1);          // before start
        send_query(32'sh0009_0000, -32'sh3);          // past end
        send_query(32'sh0002_0000, 32'sh0007_0000);   // equidistant from both ends, interior
        send_query(32'sh0, 32'sh0001_0000);           // projection exactly at start
        send_query(32'sh0004_0000, 32'sh0001_0000);   // projection exactly at end
        load_segment(32'sh0, 32'sh0, 32'sh3, 32'sh1);
        send_query(32'sh1, 32'sh2);                   // rounding ties
        send_query(32'sh2, -32'sh1);
        load_segment(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_query(32'sh7fff_ffff, 32'sh8000_0000);   // widest diagonal
        send_query(32'sh8000_0000, 32'sh7fff_ffff);
        send_query(32'sh0, 32'sh0);
        send_query(32'sh7fff_ffff, 32'sh7fff_ffff);
        load_segment(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
        send_query(32'sh1234_5678, -32'sh0bad_cafe);
        send_query(32'sh8000_0000, 32'sh8000_0000);
        load_segment(32'sh5555_5555, -32'sh2aaa_aaab, 32'sh5555_5555, -32'sh2aaa_aaab);
        send_query(32'sh0, 32'sh7fff_ffff);           // degenerate segment
    endtask

    // Random segments, each followed by a burst of random queries.
    task automatic test_random_queries();
        int span;
        int burst;
        repeat (40) begin
            span = ($urandom_range(0, 1) != 0) ? 8 : 32'h0fff_ffff;
            if ($urandom_range(0, 9) == 0)
                load_segment(rand_coord(span), rand_coord(span),
                             rand_coord(span), rand_coord(span));
            else begin
                t_coord ax, ay;
                ax = rand_coord(span);
                ay = rand_coord(span);
                load_segment(ax, ay,
                             $urandom_range(0, 5) == 0 ? ax : rand_coord(span),
                             rand_coord(span));
            end
            burst = $urandom_range(15, 45);
            sender_may_idle = ($urandom_range(0, 3) != 0);
            repeat (burst) send_query(rand_coord(span), rand_coord(span));
        end
        sender_may_idle = 1'b1;
    endtask

    // Check each result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (nearest_q.size() == 0) begin
                $error("result with no query outstanding");
                mismatches++;
            end else begin
                t_out exp_r;
                exp_r = nearest_q.pop_front();
                results_seen++;
                if (o_result.near_x !== exp_r.near_x) begin
                    $error("near_x: expected %h, got %h", exp_r.near_x, o_result.near_x);
                    mismatches++;
                end
                if (o_result.near_y !== exp_r.near_y) begin
                    $error("near_y: expected %h, got %h", exp_r.near_y, o_result.near_y);
                    mismatches++;
                end
                if (o_result.region !== exp_r.region) begin
                    $error("region: expected %0d, got %0d", exp_r.region, o_result.region);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no transaction moves either way.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_query = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_START_X;
        i_cfg_data = '0;
        seg_ax = '0; seg_ay = '0; seg_bx = '0; seg_by = '0;
        mismatches = 0;
        queries_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        segments_used = 0;
        sender_may_idle = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_segment();
        test_directed_cases();
        test_random_queries();
        drain_pipe();

        $display("Covered %0d queries over %0d segments, %0d results checked.",
                 queries_sent, segments_used, results_seen);
        $display("Interior, endpoint, tie, degenerate and extreme cases included.");
        if (mismatches == 0 && nearest_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
